/* rtl/core/cnaw_pkg.sv */
// Package for the cpio newc archive walker: phase codes, header layout
// constants, magic and trailer text, and the hex digit and mode decoders.
// No dependencies.
`default_nettype none

package cnaw_pkg;

   // Byte roles; the walker phase uses the same codes.
   localparam logic [2:0] ROLE_HEADER   = 3'd0;
   localparam logic [2:0] ROLE_NAME     = 3'd1;
   localparam logic [2:0] ROLE_NAMEPAD  = 3'd2;
   localparam logic [2:0] ROLE_DATA     = 3'd3;
   localparam logic [2:0] ROLE_DATAPAD  = 3'd4;
   localparam logic [2:0] ROLE_DONE     = 3'd5;
   localparam logic [2:0] ROLE_ERROR    = 3'd6;

   // Entry kinds.
   localparam logic [1:0] KIND_DIR     = 2'd0;
   localparam logic [1:0] KIND_REGULAR = 2'd1;
   localparam logic [1:0] KIND_SYMLINK = 2'd2;
   localparam logic [1:0] KIND_OTHER   = 2'd3;

   // Header layout, in byte positions within the header.
   localparam int          HEADER_BYTES = 110;
   localparam logic [6:0]  HDR_LAST     = 7'd109;
   localparam logic [6:0]  MAGIC_BYTES  = 7'd6;
   localparam logic [6:0]  MODE_FIRST   = 7'd14;
   localparam logic [6:0]  FSIZE_FIRST  = 7'd54;
   localparam logic [6:0]  NSIZE_FIRST  = 7'd94;
   localparam logic [6:0]  HEX_DIGITS   = 7'd8;

   // Trailer name, terminator included.
   localparam logic [31:0] TRAILER_LEN  = 32'd11;

   // File type bits of the mode word.
   localparam logic [31:0] MODE_TYPE_MASK = 32'o170000;
   localparam logic [31:0] MODE_DIR       = 32'o040000;
   localparam logic [31:0] MODE_REGULAR   = 32'o100000;
   localparam logic [31:0] MODE_SYMLINK   = 32'o120000;

   // Result fields held in tuser.
   typedef struct packed {
      logic       archive_finished;
      logic       magic_error;
      logic       header_complete;
      logic [1:0] entry_kind;
      logic [2:0] byte_role;
   } rsp_flags_type;

   // Character of the magic "070701" at a position.
   function automatic logic [7:0] magic_char(input logic [2:0] idx);
      logic [7:0] c;
      begin
         case (idx)
            3'd0, 3'd2, 3'd4: c = 8'h30;
            3'd1, 3'd3:       c = 8'h37;
            default:          c = 8'h31;
         endcase
         return c;
      end
   endfunction

   // Character of "TRAILER!!!" plus its terminating zero at a position.
   function automatic logic [7:0] trailer_char(input logic [3:0] idx);
      logic [7:0] c;
      begin
         case (idx)
            4'd0:                c = 8'h54;
            4'd1:                c = 8'h52;
            4'd2:                c = 8'h41;
            4'd3:                c = 8'h49;
            4'd4:                c = 8'h4C;
            4'd5:                c = 8'h45;
            4'd6:                c = 8'h52;
            4'd7, 4'd8, 4'd9:    c = 8'h21;
            default:             c = 8'h00;
         endcase
         return c;
      end
   endfunction

   // Hex digit decode: bit 4 is set when the character is a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      begin
         if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
         end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            r = {1'b1, b[3:0] + 4'd9};
         end else begin
            r = 5'd0;
         end
         return r;
      end
   endfunction

   // Entry kind from the file type bits of the mode.
   function automatic logic [1:0] kind_of_mode(input logic [31:0] m);
      logic [31:0] t;
      logic [1:0]  k;
      begin
         t = m & MODE_TYPE_MASK;
         if (t == MODE_DIR) begin
            k = KIND_DIR;
         end else if (t == MODE_REGULAR) begin
            k = KIND_REGULAR;
         end else if (t == MODE_SYMLINK) begin
            k = KIND_SYMLINK;
         end else begin
            k = KIND_OTHER;
         end
         return k;
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/core/cpio_newc_archive_walker.sv */
// Top level of the cpio newc archive walker: walker state, per-byte decode
// and the result register. Depends on cnaw_pkg.
//
// Usage:
//   The request channel carries one archive byte per item in req_tdata and a
//   restart flag in req_tuser; restart marks the byte as the first header
//   byte of a new archive. The response channel returns one item per request
//   item: the byte echoed with the decoded file and name sizes in rsp_tdata,
//   the byte role, entry kind and status flags in rsp_tuser, and rsp_tlast on
//   the final file data byte of an entry.
//   The result of an item accepted at an edge is held in the result register
//   and valid after that edge. One item is taken per cycle while the receiver
//   takes results; the decode is a single pass of counter compares and a hex
//   shift between the walker state and the result register.
//   req_tready is high while the result register is empty or being taken, so
//   a stalled receiver holds exactly one finished result and stops further
//   input until it is taken; nothing is lost or repeated.
//   Reset empties the result register and puts the walker at the first
//   header byte of an archive at offset zero.
`default_nettype none

module cpio_newc_archive_walker (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] archive_byte
   input  wire logic         req_tuser,   // [0] restart
   // Response channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [71:0]       rsp_tdata,   // [7:0] echoed_byte, [39:8] file_length,
                                          // [71:40] name_length
   output logic              rsp_tlast,   // last_data_byte
   output logic [7:0]        rsp_tuser    // [2:0] byte_role, [4:3] entry_kind,
                                          // [5] header_complete, [6] magic_error,
                                          // [7] archive_finished
);

   // Walker state.
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [1:0]  offset_ff, offset_in;
   logic [31:0] mode_ff, mode_in;
   logic [31:0] fsize_ff, fsize_in;
   logic [31:0] nsize_ff, nsize_in;
   logic        stopped_ff, stopped_in;
   logic        bad_ff, bad_in;
   logic        match_ff, match_in;

   // Result register.
   logic                   rsp_valid_ff;
   logic [71:0]            rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;
   cnaw_pkg::rsp_flags_type rsp_flags_ff, rsp_flags_in;

   // Decode temporaries.
   logic        accept;
   logic        restart;
   logic [7:0]  in_byte;
   logic [2:0]  cur_phase;
   logic [31:0] cur_count;
   logic [31:0] count_inc;
   logic [6:0]  hdr_idx;
   logic [4:0]  digit;
   logic [2:0]  role;
   logic        last_data;
   logic        hdr_done;
   logic        hex_run;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign restart    = req_tuser;
   assign in_byte    = req_tdata;

   // Next walker state and result for the item at the input.
   always_comb begin
      // Restart starts from the reset state.
      cur_phase  = restart ? cnaw_pkg::ROLE_HEADER : phase_ff;
      cur_count  = restart ? 32'd0 : count_ff;
      mode_in    = restart ? 32'd0 : mode_ff;
      fsize_in   = restart ? 32'd0 : fsize_ff;
      nsize_in   = restart ? 32'd0 : nsize_ff;
      stopped_in = restart ? 1'b0 : stopped_ff;
      bad_in     = restart ? 1'b0 : bad_ff;
      match_in   = restart ? 1'b1 : match_ff;
      offset_in  = (restart ? 2'd0 : offset_ff) + 2'd1;

      phase_in  = cur_phase;
      count_in  = cur_count;
      count_inc = cur_count + 32'd1;
      hdr_idx   = cur_count[6:0];
      digit     = cnaw_pkg::hex_digit(in_byte);
      role      = cur_phase;
      last_data = 1'b0;
      hdr_done  = 1'b0;
      hex_run   = 1'b0;

      unique case (cur_phase)
         cnaw_pkg::ROLE_HEADER: begin
            // Header byte 0 clears the per-entry decode.
            if (hdr_idx == 7'd0) begin
               mode_in    = 32'd0;
               fsize_in   = 32'd0;
               nsize_in   = 32'd0;
               stopped_in = 1'b0;
               match_in   = 1'b1;
            end
            if (hdr_idx < cnaw_pkg::MAGIC_BYTES &&
                in_byte != cnaw_pkg::magic_char(hdr_idx[2:0])) begin
               bad_in   = 1'b1;
               phase_in = cnaw_pkg::ROLE_ERROR;
               role     = cnaw_pkg::ROLE_ERROR;
            end else begin
               // Hex fields: each restarts the stop flag at its first digit.
               if (hdr_idx == cnaw_pkg::MODE_FIRST || hdr_idx == cnaw_pkg::FSIZE_FIRST ||
                   hdr_idx == cnaw_pkg::NSIZE_FIRST) begin
                  stopped_in = 1'b0;
               end
               hex_run = !stopped_in;
               if (hex_run && !digit[4] &&
                   ((hdr_idx >= cnaw_pkg::MODE_FIRST &&
                     hdr_idx < cnaw_pkg::MODE_FIRST + cnaw_pkg::HEX_DIGITS) ||
                    (hdr_idx >= cnaw_pkg::FSIZE_FIRST &&
                     hdr_idx < cnaw_pkg::FSIZE_FIRST + cnaw_pkg::HEX_DIGITS) ||
                    (hdr_idx >= cnaw_pkg::NSIZE_FIRST &&
                     hdr_idx < cnaw_pkg::NSIZE_FIRST + cnaw_pkg::HEX_DIGITS))) begin
                  stopped_in = 1'b1;
               end
               if (hex_run && digit[4]) begin
                  if (hdr_idx >= cnaw_pkg::MODE_FIRST &&
                      hdr_idx < cnaw_pkg::MODE_FIRST + cnaw_pkg::HEX_DIGITS) begin
                     mode_in = {mode_in[27:0], digit[3:0]};
                  end else if (hdr_idx >= cnaw_pkg::FSIZE_FIRST &&
                               hdr_idx < cnaw_pkg::FSIZE_FIRST + cnaw_pkg::HEX_DIGITS) begin
                     fsize_in = {fsize_in[27:0], digit[3:0]};
                  end else if (hdr_idx >= cnaw_pkg::NSIZE_FIRST &&
                               hdr_idx < cnaw_pkg::NSIZE_FIRST + cnaw_pkg::HEX_DIGITS) begin
                     nsize_in = {nsize_in[27:0], digit[3:0]};
                  end
               end
               count_in = count_inc;
               // End of header: go to the name, or skip an empty one.
               if (hdr_idx == cnaw_pkg::HDR_LAST) begin
                  hdr_done = 1'b1;
                  count_in = 32'd0;
                  if (nsize_in != 32'd0) begin
                     phase_in = cnaw_pkg::ROLE_NAME;
                  end else if (offset_in != 2'd0) begin
                     phase_in = cnaw_pkg::ROLE_NAMEPAD;
                  end else if (fsize_in != 32'd0) begin
                     phase_in = cnaw_pkg::ROLE_DATA;
                  end else begin
                     phase_in = cnaw_pkg::ROLE_HEADER;
                  end
               end
            end
         end
         cnaw_pkg::ROLE_NAME: begin
            // Compare the name against the trailer text as it goes by.
            if (cur_count < cnaw_pkg::TRAILER_LEN &&
                in_byte != cnaw_pkg::trailer_char(cur_count[3:0])) begin
               match_in = 1'b0;
            end
            count_in = count_inc;
            if (count_inc == nsize_in) begin
               if (match_in && nsize_in == cnaw_pkg::TRAILER_LEN) begin
                  phase_in = cnaw_pkg::ROLE_DONE;
               end else begin
                  count_in = 32'd0;
                  if (offset_in != 2'd0) begin
                     phase_in = cnaw_pkg::ROLE_NAMEPAD;
                  end else if (fsize_in != 32'd0) begin
                     phase_in = cnaw_pkg::ROLE_DATA;
                  end else begin
                     phase_in = cnaw_pkg::ROLE_HEADER;
                  end
               end
            end
         end
         cnaw_pkg::ROLE_NAMEPAD: begin
            if (offset_in == 2'd0) begin
               count_in = 32'd0;
               phase_in = (fsize_in != 32'd0) ? cnaw_pkg::ROLE_DATA : cnaw_pkg::ROLE_HEADER;
            end
         end
         cnaw_pkg::ROLE_DATA: begin
            count_in = count_inc;
            if (count_inc == fsize_in) begin
               last_data = 1'b1;
               count_in  = 32'd0;
               phase_in  = (offset_in == 2'd0) ? cnaw_pkg::ROLE_HEADER
                                                : cnaw_pkg::ROLE_DATAPAD;
            end
         end
         cnaw_pkg::ROLE_DATAPAD: begin
            if (offset_in == 2'd0) begin
               count_in = 32'd0;
               phase_in = cnaw_pkg::ROLE_HEADER;
            end
         end
         cnaw_pkg::ROLE_DONE: begin
            role = cnaw_pkg::ROLE_DONE;
         end
         default: begin
            phase_in = cnaw_pkg::ROLE_ERROR;
            role     = cnaw_pkg::ROLE_ERROR;
         end
      endcase

      // Result item.
      rsp_data_in                   = {nsize_in, fsize_in, in_byte};
      rsp_last_in                   = last_data;
      rsp_flags_in.byte_role        = role;
      rsp_flags_in.entry_kind       = cnaw_pkg::kind_of_mode(mode_in);
      rsp_flags_in.header_complete  = hdr_done;
      rsp_flags_in.magic_error      = bad_in;
      rsp_flags_in.archive_finished = (phase_in == cnaw_pkg::ROLE_DONE);
   end

   // Walker state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= cnaw_pkg::ROLE_HEADER;
         count_ff   <= 32'd0;
         offset_ff  <= 2'd0;
         mode_ff    <= 32'd0;
         fsize_ff   <= 32'd0;
         nsize_ff   <= 32'd0;
         stopped_ff <= 1'b0;
         bad_ff     <= 1'b0;
         match_ff   <= 1'b1;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         offset_ff  <= offset_in;
         mode_ff    <= mode_in;
         fsize_ff   <= fsize_in;
         nsize_ff   <= nsize_in;
         stopped_ff <= stopped_in;
         bad_ff     <= bad_in;
         match_ff   <= match_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_flags_ff;

   // A latched magic error shows only on error bytes.
   a_error_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.magic_error |->
         rsp_flags_ff.byte_role == cnaw_pkg::ROLE_ERROR)
      else $error("magic error flagged on a byte that is not an error byte");

   // The last data mark falls only on file data.
   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_flags_ff.byte_role == cnaw_pkg::ROLE_DATA)
      else $error("last data mark on a byte that is not file data");

   // Header completion falls only on a header byte.
   a_hdr_done_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.header_complete |->
         rsp_flags_ff.byte_role == cnaw_pkg::ROLE_HEADER)
      else $error("header completion on a byte outside the header");

   // The archive ends on the last name byte or stays ended.
   a_finish_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.archive_finished |->
         (rsp_flags_ff.byte_role == cnaw_pkg::ROLE_NAME ||
          rsp_flags_ff.byte_role == cnaw_pkg::ROLE_DONE))
      else $error("archive end flagged on an unexpected byte role");

   // The walker never rests in an undefined phase code.
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      accept |=> phase_ff != 3'd7)
      else $error("walker phase holds an undefined code");

endmodule

`default_nettype wire

/* verif/tb_cpio_newc_archive_walker.sv */
// Self-checking testbench for the cpio newc archive walker: directed bytes, then random
// archives with random idling on both streams, each result checked against a predictor.
// Depends on cnaw_pkg and cpio_newc_archive_walker.
`default_nettype none

module tb_cpio_newc_archive_walker;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 850;
   localparam int DIRECTED_ROWS = 19;
   localparam int HOLD_START   = 600;
   localparam int HOLD_CYCLES  = 200;
   localparam int CALM_START   = 1200;
   localparam int CALM_END     = 1500;

   localparam logic [47:0] MAGIC_TEXT   = "070701";
   localparam logic [87:0] TRAILER_TEXT = {"TRAILER!!!", 8'h00};

   // One byte offered to the walker, with an optional hand-typed role and error flag.
   typedef struct packed {
      logic [7:0] data;
      logic       restart;
      logic       checked;
      logic [2:0] role;
      logic       magic_err;
   } stim_type;

   // Everything the walker reports about one byte.
   typedef struct packed {
      logic [2:0]  role;
      logic [7:0]  echo;
      logic        last;
      logic [1:0]  kind;
      logic [31:0] flen;
      logic [31:0] nlen;
      logic        hdone;
      logic        merr;
      logic        fin;
   } byte_tag_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;   // [7:0] archive_byte
   logic          req_tuser;   // [0] restart
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [71:0]   rsp_tdata;   // [7:0] echoed_byte, [39:8] file_length, [71:40] name_length
   logic          rsp_tlast;   // last_data_byte
   logic [7:0]    rsp_tuser;   // [2:0] byte_role, [4:3] entry_kind, [5] header_complete,
                               // [6] magic_error, [7] archive_finished
   cnaw_pkg::rsp_flags_type got_flags;

   // Hand-typed expectation of the item on offer.
   logic          offer_checked;
   logic [2:0]    offer_role;
   logic          offer_merr;

   stim_type      archive_bytes[$];
   byte_tag_type  tags_due[$];
   int            gen_offset = 0;
   int            cycle_count = 0;
   int            mismatches = 0;

   // Predicted walker state.
   logic [2:0]    w_phase;
   logic [31:0]   w_count;
   logic [1:0]    w_offset;
   logic [31:0]   w_mode;
   logic [31:0]   w_fsize;
   logic [31:0]   w_nsize;
   logic          w_halt;
   logic          w_badmagic;
   logic          w_trailer_ok;

   assign got_flags = rsp_tuser;

   cpio_newc_archive_walker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] magic_at(input int i);
      return MAGIC_TEXT[8*(5-i) +: 8];
   endfunction

   function automatic logic [7:0] trailer_at(input int i);
      return TRAILER_TEXT[8*(10-i) +: 8];
   endfunction

   // Bit 4 flags a hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd0;
         if (c >= "0" && c <= "9") begin
            d = c - "0";
            return {1'b1, d[3:0]};
         end
         if (c >= "A" && c <= "F") begin
            d = c - "A" + 8'd10;
            return {1'b1, d[3:0]};
         end
         if (c >= "a" && c <= "f") begin
            d = c - "a" + 8'd10;
            return {1'b1, d[3:0]};
         end
         return 5'd0;
      end
   endfunction

   // Kind of entry from the file type nibble of the mode.
   function automatic logic [1:0] mode_kind(input logic [31:0] m);
      case (m[15:12])
         4'b0100: return cnaw_pkg::KIND_DIR;
         4'b1000: return cnaw_pkg::KIND_REGULAR;
         4'b1010: return cnaw_pkg::KIND_SYMLINK;
         default: return cnaw_pkg::KIND_OTHER;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   task automatic walker_reset();
      w_phase      = cnaw_pkg::ROLE_HEADER;
      w_count      = 32'd0;
      w_offset     = 2'd0;
      w_mode       = 32'd0;
      w_fsize      = 32'd0;
      w_nsize      = 32'd0;
      w_halt       = 1'b0;
      w_badmagic   = 1'b0;
      w_trailer_ok = 1'b1;
   endtask

   // A header field takes digits until its first non-hex character.
   task automatic shift_hex(inout logic [31:0] acc, input logic [7:0] c);
      logic [4:0] h;
      begin
         h = hex_nibble(c);
         if (!w_halt) begin
            if (h[4]) acc = {acc[27:0], h[3:0]};
            else w_halt = 1'b1;
         end
      end
   endtask

   task automatic go_header();
      w_phase = cnaw_pkg::ROLE_HEADER;
      w_count = 32'd0;
   endtask

   task automatic go_datapad();
      if (w_offset == 2'd0) begin
         go_header();
      end else begin
         w_phase = cnaw_pkg::ROLE_DATAPAD;
         w_count = 32'd0;
      end
   endtask

   task automatic go_data();
      w_count = 32'd0;
      if (w_fsize != 32'd0) w_phase = cnaw_pkg::ROLE_DATA;
      else go_datapad();
   endtask

   task automatic go_namepad();
      if (w_offset == 2'd0) begin
         go_data();
      end else begin
         w_phase = cnaw_pkg::ROLE_NAMEPAD;
         w_count = 32'd0;
      end
   endtask

   // Works out the tag of one archive byte and advances the walker.
   task automatic tag_byte(input logic [7:0] b, input logic restart,
                           output byte_tag_type tag);
      logic [31:0] idx;
      begin
         if (restart) walker_reset();
         tag = '0;
         tag.role = w_phase;
         tag.echo = b;
         w_offset = w_offset + 2'd1;
         case (w_phase)
            cnaw_pkg::ROLE_HEADER: begin
               idx = w_count;
               if (idx == 32'd0) begin
                  w_mode       = 32'd0;
                  w_fsize      = 32'd0;
                  w_nsize      = 32'd0;
                  w_halt       = 1'b0;
                  w_trailer_ok = 1'b1;
               end
               if (idx < cnaw_pkg::MAGIC_BYTES && b != magic_at(idx)) begin
                  w_badmagic = 1'b1;
                  w_phase    = cnaw_pkg::ROLE_ERROR;
                  tag.role   = cnaw_pkg::ROLE_ERROR;
               end else begin
                  if (idx == cnaw_pkg::MODE_FIRST || idx == cnaw_pkg::FSIZE_FIRST ||
                      idx == cnaw_pkg::NSIZE_FIRST)
                     w_halt = 1'b0;
                  if (idx >= cnaw_pkg::MODE_FIRST &&
                      idx < cnaw_pkg::MODE_FIRST + cnaw_pkg::HEX_DIGITS)
                     shift_hex(w_mode, b);
                  else if (idx >= cnaw_pkg::FSIZE_FIRST &&
                           idx < cnaw_pkg::FSIZE_FIRST + cnaw_pkg::HEX_DIGITS)
                     shift_hex(w_fsize, b);
                  else if (idx >= cnaw_pkg::NSIZE_FIRST &&
                           idx < cnaw_pkg::NSIZE_FIRST + cnaw_pkg::HEX_DIGITS)
                     shift_hex(w_nsize, b);
                  w_count = idx + 32'd1;
                  if (w_count >= cnaw_pkg::HEADER_BYTES) begin
                     tag.hdone = 1'b1;
                     w_count   = 32'd0;
                     if (w_nsize != 32'd0) w_phase = cnaw_pkg::ROLE_NAME;
                     else go_namepad();
                  end
               end
            end
            cnaw_pkg::ROLE_NAME: begin
               if (w_count < cnaw_pkg::TRAILER_LEN && b != trailer_at(w_count))
                  w_trailer_ok = 1'b0;
               w_count = w_count + 32'd1;
               if (w_count == w_nsize) begin
                  if (w_trailer_ok && w_nsize == cnaw_pkg::TRAILER_LEN)
                     w_phase = cnaw_pkg::ROLE_DONE;
                  else go_namepad();
               end
            end
            cnaw_pkg::ROLE_NAMEPAD: begin
               if (w_offset == 2'd0) go_data();
            end
            cnaw_pkg::ROLE_DATA: begin
               w_count = w_count + 32'd1;
               if (w_count == w_fsize) begin
                  tag.last = 1'b1;
                  go_datapad();
               end
            end
            cnaw_pkg::ROLE_DATAPAD: begin
               if (w_offset == 2'd0) go_header();
            end
            cnaw_pkg::ROLE_DONE: begin
               tag.role = cnaw_pkg::ROLE_DONE;
            end
            default: begin
               w_phase  = cnaw_pkg::ROLE_ERROR;
               tag.role = cnaw_pkg::ROLE_ERROR;
            end
         endcase
         tag.kind  = mode_kind(w_mode);
         tag.flen  = w_fsize;
         tag.nlen  = w_nsize;
         tag.merr  = w_badmagic;
         tag.fin   = (w_phase == cnaw_pkg::ROLE_DONE);
      end
   endtask

   // ---------------------------------------------------------------------
   // Archive generator
   // ---------------------------------------------------------------------

   task automatic push_byte(input logic [7:0] b, input logic restart);
      stim_type s;
      begin
         s = '0;
         s.data    = b;
         s.restart = restart;
         s.role    = cnaw_pkg::ROLE_HEADER;
         archive_bytes.push_back(s);
         if (restart) gen_offset = 0;
         gen_offset++;
      end
   endtask

   task automatic push_random(input int n);
      repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic push_pad();
      while (gen_offset % 4 != 0) push_byte(8'($urandom_range(255)), 1'b0);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + 8'(n);
      return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
   endfunction

   // Eight-digit field. A stopped field carries only the significant digits, then a
   // non-hex character and junk, so it decodes to the same value.
   task automatic push_hex(input logic [31:0] v, input logic stop);
      int         digits;
      int         i;
      logic [7:0] c;
      logic [4:0] h;
      begin
         digits = 8;
         if (stop) begin
            digits = 1;
            for (i = 1; i < 8; i++) if ((v >> (4 * i)) != 32'd0) digits = i + 1;
         end
         for (i = digits - 1; i >= 0; i--) push_byte(hex_char(v[4*i +: 4]), 1'b0);
         if (digits < 8) begin
            do begin
               c = 8'($urandom_range(255));
               h = hex_nibble(c);
            end while (h[4]);
            push_byte(c, 1'b0);
            push_random(7 - digits);
         end
      end
   endtask

   // A 110-byte header; bad_pos picks a magic byte to spoil, or none when negative.
   task automatic push_header(input logic restart, input int bad_pos, input logic [31:0] mode,
                              input logic [31:0] fsize, input logic [31:0] nsize,
                              input logic [2:0] stops);
      int         i;
      logic [7:0] c;
      logic [7:0] good;
      begin
         for (i = 0; i < 6; i++) begin
            good = magic_at(i);
            c    = good;
            if (i == bad_pos) begin
               do c = 8'($urandom_range(255)); while (c == good);
            end
            push_byte(c, restart && i == 0);
         end
         push_random(8);
         push_hex(mode, stops[0]);
         push_random(32);
         push_hex(fsize, stops[1]);
         push_random(32);
         push_hex(nsize, stops[2]);
         push_random(8);
      end
   endtask

   function automatic logic [31:0] random_mode();
      logic [31:0] perms;
      begin
         perms = $urandom_range(12'o7777);
         case ($urandom_range(4))
            0:       return cnaw_pkg::MODE_DIR | perms;
            1:       return cnaw_pkg::MODE_REGULAR | perms;
            2:       return cnaw_pkg::MODE_SYMLINK | perms;
            3:       return (32'($urandom_range(15)) << 12) | perms;
            default: return $urandom;
         endcase
      end
   endfunction

   function automatic logic [2:0] random_stops();
      return {$urandom_range(99) < 15, $urandom_range(99) < 15, $urandom_range(99) < 15};
   endfunction

   // An ordinary entry; some names look like the trailer but never match it.
   task automatic push_entry(input logic restart);
      logic [31:0] nsize;
      logic [31:0] fsize;
      logic        like_trailer;
      int          flip;
      int          i;
      logic [7:0]  c;
      begin
         nsize        = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(14, 1);
         fsize        = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(16, 1);
         like_trailer = ($urandom_range(4) == 0);
         flip         = $urandom_range(10);
         push_header(restart, -1, random_mode(), fsize, nsize, random_stops());
         for (i = 0; i < nsize; i++) begin
            c = 8'($urandom_range(255));
            if (like_trailer && i < cnaw_pkg::TRAILER_LEN) c = trailer_at(i);
            if (like_trailer && nsize == cnaw_pkg::TRAILER_LEN && i == flip) c = c ^ 8'h20;
            push_byte(c, 1'b0);
         end
         push_pad();
         push_random(fsize);
         push_pad();
      end
   endtask

   // The closing entry and a few bytes after the archive has ended.
   task automatic push_trailer(input logic restart);
      int i;
      begin
         push_header(restart, -1, random_mode(), 32'd0, cnaw_pkg::TRAILER_LEN,
                     random_stops());
         for (i = 0; i < cnaw_pkg::TRAILER_LEN; i++) push_byte(trailer_at(i), 1'b0);
         push_random($urandom_range(8));
      end
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   task automatic check_result();
      byte_tag_type want;
      begin
         if (tags_due.size() == 0) begin
            mismatches++;
            $display("%0t: result item with no byte waiting, expected none, actual %0h/%0h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = tags_due.pop_front();
            check_field("byte_role", want.role, got_flags.byte_role);
            check_field("echoed_byte", want.echo, rsp_tdata[7:0]);
            check_field("last_data_byte", want.last, rsp_tlast);
            check_field("entry_kind", want.kind, got_flags.entry_kind);
            check_field("file_length", want.flen, rsp_tdata[39:8]);
            check_field("name_length", want.nlen, rsp_tdata[71:40]);
            check_field("header_complete", want.hdone, got_flags.header_complete);
            check_field("magic_error", want.merr, got_flags.magic_error);
            check_field("archive_finished", want.fin, got_flags.archive_finished);
         end
      end
   endtask

   task automatic take_item();
      byte_tag_type tag;
      begin
         tag_byte(req_tdata, req_tuser, tag);
         if (offer_checked) begin
            tag.role = offer_role;
            tag.merr = offer_merr;
         end
         tags_due.push_back(tag);
      end
   endtask

   // Both handshakes are sampled at the edge, before any driver updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) take_item();
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold-off, and a calm stretch.
   initial begin
      int rx_cycles;
      rx_cycles = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycles++;
         if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES)
            rsp_tready <= 1'b0;
         else if (rx_cycles >= CALM_START && rx_cycles < CALM_END)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(99) >= 36);
      end
   end

   // Stimulus build, reset and sender.
   initial begin
      stim_type    directed_rows [DIRECTED_ROWS];
      stim_type    s;
      int          k;
      int          n;
      int          e;
      logic [31:0] big;
      logic [31:0] nsize;

      walker_reset();
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= 8'd0;
      req_tuser     <= 1'b0;
      offer_checked <= 1'b0;
      offer_role    <= cnaw_pkg::ROLE_HEADER;
      offer_merr    <= 1'b0;

      // byte, restart, typed, role, magic_error
      directed_rows = '{
         '{"0",   1'b0, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},  // straight after reset
         '{"7",   1'b0, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},
         '{8'hFF, 1'b0, 1'b1, cnaw_pkg::ROLE_ERROR,  1'b1},  // third magic byte wrong
         '{8'h00, 1'b0, 1'b1, cnaw_pkg::ROLE_ERROR,  1'b1},  // error stays latched
         '{"0",   1'b1, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},  // restart clears the error
         '{8'h00, 1'b0, 1'b1, cnaw_pkg::ROLE_ERROR,  1'b1},
         '{8'hFF, 1'b1, 1'b1, cnaw_pkg::ROLE_ERROR,  1'b1},  // restart on a bad first byte
         '{"0",   1'b1, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},
         '{"7",   1'b0, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},
         '{"0",   1'b0, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},
         '{"7",   1'b0, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},
         '{"0",   1'b0, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},
         '{"1",   1'b0, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},  // whole magic accepted
         '{8'hFF, 1'b0, 1'b0, cnaw_pkg::ROLE_HEADER, 1'b0},
         '{8'h00, 1'b0, 1'b0, cnaw_pkg::ROLE_HEADER, 1'b0},
         '{"0",   1'b1, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0},  // restart in mid-header
         '{"1",   1'b0, 1'b1, cnaw_pkg::ROLE_ERROR,  1'b1},
         '{"7",   1'b0, 1'b1, cnaw_pkg::ROLE_ERROR,  1'b1},
         '{"0",   1'b1, 1'b1, cnaw_pkg::ROLE_HEADER, 1'b0}
      };
      for (k = 0; k < DIRECTED_ROWS; k++) archive_bytes.push_back(directed_rows[k]);

      // Mostly well-formed archives, with spoiled magic, oversized fields and noise.
      while (archive_bytes.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         case ($urandom_range(9))
            7: begin
               push_header(1'b1, $urandom_range(5), random_mode(), $urandom_range(16),
                           $urandom_range(14), random_stops());
               push_random($urandom_range(10));
            end
            8: begin
               // Sizes too large to finish; the next restart cuts the entry short.
               big   = $urandom_range(1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
               nsize = $urandom_range(1) ? $urandom_range(6, 1) : big;
               push_header(1'b1, -1, random_mode(), big, nsize, random_stops());
               if (nsize < 32'd7) begin
                  push_random(nsize);
                  push_pad();
               end
               push_random($urandom_range(20));
            end
            9: begin
               repeat ($urandom_range(30, 5))
                  push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            end
            default: begin
               n = $urandom_range(3);
               for (e = 0; e < n; e++) push_entry(e == 0);
               if (n == 0 || $urandom_range(9) < 6) push_trailer(n == 0);
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < archive_bytes.size(); k++) begin
         s = archive_bytes[k];
         while (!(cycle_count >= CALM_START && cycle_count < CALM_END)
                && $urandom_range(99) < 36) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid    <= 1'b1;
         req_tdata     <= s.data;
         req_tuser     <= s.restart;
         offer_checked <= s.checked;
         offer_role    <= s.role;
         offer_merr    <= s.magic_err;
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;

      // Drain the results, then allow a few more cycles for stray output.
      @(posedge clock);
      while (tags_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
